FILE: hw/rtl/rrs_pkg.sv
`timescale 1ns / 1ps

package rrs_pkg;

  // Table size and derived widths
  localparam int MaxProcs = 16;
  localparam int IdxW     = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int CntW     = $clog2(MaxProcs + 1);

  // Field widths
  localparam int OpW     = 2;
  localparam int ArrW    = 16;
  localparam int BurstW  = 16;
  localparam int PidW    = 5;
  localparam int SliceW  = 8;
  localparam int QuantW  = 8;
  localparam int TimeW   = 21;

  localparam logic [TimeW-1:0]  TimeMax      = {TimeW{1'b1}};
  localparam logic [QuantW-1:0] QuantumReset = QuantW'(4);

  // Request op codes
  localparam logic [OpW-1:0] OpLoad     = 2'd0;
  localparam logic [OpW-1:0] OpDispatch = 2'd1;
  localparam logic [OpW-1:0] OpClear    = 2'd2;

  typedef struct packed {
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
    logic [PidW-1:0]   pid;
    logic [BurstW-1:0] remaining;
    logic [TimeW-1:0]  response;
    logic              started;
  } entry_t;

endpackage

FILE: hw/rtl/rrs_intf.sv
`timescale 1ns / 1ps

interface rrs_req_if;
  logic                          valid;
  logic                          ready;
  logic [rrs_pkg::OpW-1:0]       op;
  logic [rrs_pkg::ArrW-1:0]      arrival_time;
  logic [rrs_pkg::BurstW-1:0]    burst_len;

  modport source (output valid, op, arrival_time, burst_len, input ready);
  modport sink   (input valid, op, arrival_time, burst_len, output ready);
endinterface

interface rrs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rrs_pkg::PidW-1:0]      pid;
  logic [rrs_pkg::SliceW-1:0]    slice_length;
  logic [rrs_pkg::TimeW-1:0]     end_time;
  logic                          finished;
  logic [rrs_pkg::TimeW-1:0]     resp_delay;
  logic [rrs_pkg::TimeW-1:0]     turnaround_time;
  logic [rrs_pkg::TimeW-1:0]     wait_len;
  logic                          all_done;

  modport source (output valid, pid, slice_length, end_time, finished, resp_delay,
                  turnaround_time, wait_len, all_done, input ready);
  modport sink   (input valid, pid, slice_length, end_time, finished, resp_delay,
                  turnaround_time, wait_len, all_done, output ready);
endinterface

FILE: hw/rtl/round_robin_cpu_scheduler_core.sv
// Channel     Dir  Handshake     Contents
// req_i       in   valid/ready   op, arrival_time, burst_len
// rsp_o       out  valid/ready   pid, slice_length, end_time, finished, response,
//                                turnaround and waiting time, all_done
// cfg_*       in   write enable  quantum
//
// One request at a time; ready is high only while the sequencer is idle.
// Load, if the table has room: scan for the slot, shift entries up, write the new one.
// Dispatch: admit arrived processes (jumping time when none is ready), run one slice,
// advance time, admit again, requeue, then respond; with nothing left, only respond.
// Clear and unknown ops finish in idle; one table read port serializes scan and shift.
// A result waits in the output register; the sequencer holds only if it is still full.
// Reset is asynchronous; the tables hold no reset and are read only where written.
`timescale 1ns / 1ps

module round_robin_cpu_scheduler_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rrs_pkg::QuantW-1:0] cfg_data_i,
  rrs_req_if.sink                    req_i,
  rrs_rsp_if.source                  rsp_o
);

  localparam int StW = 3;
  localparam logic [StW-1:0] StIdle  = 3'd0;
  localparam logic [StW-1:0] StScan  = 3'd1;
  localparam logic [StW-1:0] StShift = 3'd2;
  localparam logic [StW-1:0] StAdmit = 3'd3;
  localparam logic [StW-1:0] StRun   = 3'd4;
  localparam logic [StW-1:0] StAdv   = 3'd5;
  localparam logic [StW-1:0] StPost  = 3'd6;
  localparam logic [StW-1:0] StOut   = 3'd7;

  localparam int IdxW  = rrs_pkg::IdxW;
  localparam int CntW  = rrs_pkg::CntW;
  localparam int TimeW = rrs_pkg::TimeW;

  logic [StW-1:0]             state_q, state_d;
  logic [rrs_pkg::QuantW-1:0] quantum_q;

  rrs_pkg::entry_t            tab_q [rrs_pkg::MaxProcs];
  logic [IdxW-1:0]            rq_q  [rrs_pkg::MaxProcs];

  logic [IdxW-1:0]            head_q, head_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            loaded_q, loaded_d;
  logic [CntW-1:0]            nta_q, nta_d;
  logic [TimeW-1:0]           time_q, time_d;
  logic [CntW-1:0]            pos_q, pos_d;
  logic [CntW-1:0]            k_q, k_d;
  logic [rrs_pkg::ArrW-1:0]   new_arr_q, new_arr_d;
  logic [rrs_pkg::BurstW-1:0] new_burst_q, new_burst_d;
  logic [IdxW-1:0]            cur_q, cur_d;
  logic [rrs_pkg::SliceW-1:0] run_q, run_d;
  logic [TimeW-1:0]           tat_q, tat_d;
  logic                       fin_q, fin_d;
  logic                       done_q, done_d;

  logic                       rsp_valid_q;
  logic                       rsp_load;
  logic                       rsp_free;

  // Table read and write port
  logic [IdxW-1:0]            rd_idx;
  rrs_pkg::entry_t            rd;
  logic                       tab_we;
  logic [IdxW-1:0]            tab_wa;
  rrs_pkg::entry_t            tab_wd;

  // Ready queue write port
  logic                       rq_we;
  logic [IdxW-1:0]            rq_wd;
  logic [CntW:0]              tail_sum;
  logic [IdxW-1:0]            tail;
  logic [IdxW-1:0]            head_inc;

  logic [TimeW-1:0]           rd_arr_t;
  logic                       admit_ok;
  logic [rrs_pkg::QuantW-1:0] q_eff;
  logic [rrs_pkg::BurstW-1:0] run_full;
  logic [TimeW:0]             time_sum;
  logic [TimeW-1:0]           time_next;
  logic [CntW:0]              pid_sum;
  logic [TimeW-1:0]           burst_t;
  logic [TimeW-1:0]           wt;
  logic                       accept;

  assign accept    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == StIdle);
  assign rsp_free  = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    case (state_q)
      StScan:          rd_idx = pos_q[IdxW-1:0];
      StShift:         rd_idx = IdxW'(k_q - CntW'(1));
      StAdmit, StPost: rd_idx = nta_q[IdxW-1:0];
      StRun:           rd_idx = rq_q[head_q];
      default:         rd_idx = cur_q;
    endcase
  end

  assign rd       = tab_q[rd_idx];
  assign rd_arr_t = TimeW'(rd.arrival);
  assign admit_ok = (nta_q < loaded_q) && (rd_arr_t <= time_q);

  assign tail_sum = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign tail     = (tail_sum >= (CntW+1)'(rrs_pkg::MaxProcs))
                    ? IdxW'(tail_sum - (CntW+1)'(rrs_pkg::MaxProcs))
                    : IdxW'(tail_sum);
  assign head_inc = (head_q == IdxW'(rrs_pkg::MaxProcs - 1)) ? '0 : head_q + IdxW'(1);

  assign q_eff     = (quantum_q == '0) ? rrs_pkg::QuantW'(1) : quantum_q;
  assign run_full  = (rd.remaining < rrs_pkg::BurstW'(q_eff)) ? rd.remaining
                                                                : rrs_pkg::BurstW'(q_eff);
  assign time_sum  = (TimeW+1)'(time_q) + (TimeW+1)'(run_q);
  assign time_next = time_sum[TimeW] ? rrs_pkg::TimeMax : time_sum[TimeW-1:0];
  assign pid_sum   = (CntW+1)'(loaded_q) + (CntW+1)'(1);
  assign burst_t   = TimeW'(rd.burst);
  assign wt        = (tat_q >= burst_t) ? tat_q - burst_t : '0;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    loaded_d    = loaded_q;
    nta_d       = nta_q;
    time_d      = time_q;
    pos_d       = pos_q;
    k_d         = k_q;
    new_arr_d   = new_arr_q;
    new_burst_d = new_burst_q;
    cur_d       = cur_q;
    run_d       = run_q;
    tat_d       = tat_q;
    fin_d       = fin_q;
    done_d      = done_q;
    tab_we      = 1'b0;
    tab_wa      = rd_idx;
    tab_wd      = rd;
    rq_we       = 1'b0;
    rq_wd       = nta_q[IdxW-1:0];
    rsp_load    = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (req_i.op)
            rrs_pkg::OpLoad: begin
              if (loaded_q < CntW'(rrs_pkg::MaxProcs)) begin
                new_arr_d   = req_i.arrival_time;
                new_burst_d = req_i.burst_len;
                pos_d       = nta_q;
                state_d     = StScan;
              end
            end
            rrs_pkg::OpDispatch: begin
              state_d = StAdmit;
            end
            rrs_pkg::OpClear: begin
              head_d   = '0;
              count_d  = '0;
              loaded_d = '0;
              nta_d    = '0;
              time_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Find the first slot past equal arrivals to keep load order.
      StScan: begin
        if (pos_q < loaded_q && rd.arrival <= new_arr_q) begin
          pos_d = pos_q + CntW'(1);
        end else begin
          k_d     = loaded_q;
          state_d = StShift;
        end
      end

      StShift: begin
        tab_we = 1'b1;
        if (k_q > pos_q) begin
          tab_wa = k_q[IdxW-1:0];
          tab_wd = rd;
          k_d    = k_q - CntW'(1);
        end else begin
          tab_wa           = pos_q[IdxW-1:0];
          tab_wd.arrival   = new_arr_q;
          tab_wd.burst     = new_burst_q;
          tab_wd.pid       = rrs_pkg::PidW'(pid_sum);
          tab_wd.remaining = new_burst_q;
          tab_wd.response  = '0;
          tab_wd.started   = 1'b0;
          loaded_d         = loaded_q + CntW'(1);
          state_d          = StIdle;
        end
      end

      // Admit arrived processes; jump time forward when nothing is ready.
      StAdmit: begin
        if (admit_ok) begin
          rq_we   = 1'b1;
          count_d = count_q + CntW'(1);
          nta_d   = nta_q + CntW'(1);
        end else if (count_q == '0 && nta_q < loaded_q) begin
          time_d = rd_arr_t;
        end else if (count_q == '0) begin
          done_d  = 1'b1;
          state_d = StOut;
        end else begin
          done_d  = 1'b0;
          state_d = StRun;
        end
      end

      StRun: begin
        cur_d            = rd_idx;
        head_d           = head_inc;
        count_d          = count_q - CntW'(1);
        run_d            = rrs_pkg::SliceW'(run_full);
        fin_d            = (rd.remaining == run_full);
        tab_we           = 1'b1;
        tab_wa           = rd_idx;
        tab_wd.remaining = rd.remaining - run_full;
        if (!rd.started) begin
          tab_wd.started  = 1'b1;
          tab_wd.response = time_q - rd_arr_t;
        end
        state_d = StAdv;
      end

      // Advance time; rd points at the current process here.
      StAdv: begin
        time_d  = time_next;
        tat_d   = time_next - rd_arr_t;
        state_d = StPost;
      end

      // Admit by the new time, then requeue the unfinished process.
      StPost: begin
        if (admit_ok) begin
          rq_we   = 1'b1;
          count_d = count_q + CntW'(1);
          nta_d   = nta_q + CntW'(1);
        end else begin
          state_d = StOut;
          if (!fin_q) begin
            rq_we   = 1'b1;
            rq_wd   = cur_q;
            count_d = count_q + CntW'(1);
          end
        end
      end

      StOut: begin
        if (rsp_free) begin
          rsp_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      quantum_q <= rrs_pkg::QuantumReset;
      head_q    <= '0;
      count_q   <= '0;
      loaded_q  <= '0;
      nta_q     <= '0;
      time_q    <= '0;
      pos_q     <= '0;
      k_q       <= '0;
      cur_q     <= '0;
      run_q     <= '0;
      tat_q     <= '0;
      fin_q     <= 1'b0;
      done_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_data_i;
      end
      head_q  <= head_d;
      count_q <= count_d;
      loaded_q <= loaded_d;
      nta_q   <= nta_d;
      time_q  <= time_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      cur_q   <= cur_d;
      run_q   <= run_d;
      tat_q   <= tat_d;
      fin_q   <= fin_d;
      done_q  <= done_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_arr_q   <= new_arr_d;
    new_burst_q <= new_burst_d;
    if (tab_we) begin
      tab_q[tab_wa] <= tab_wd;
    end
    if (rq_we) begin
      rq_q[tail] <= rq_wd;
    end
  end

  // Output register
  logic [rrs_pkg::PidW-1:0]   pid_q;
  logic [rrs_pkg::SliceW-1:0] slice_q;
  logic [TimeW-1:0]           end_q, resp_q, tatr_q, wait_q;
  logic                       finr_q, doner_q;

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      pid_q   <= done_q ? '0 : rd.pid;
      slice_q <= done_q ? '0 : run_q;
      end_q   <= done_q ? '0 : time_q;
      finr_q  <= !done_q && fin_q;
      resp_q  <= (!done_q && fin_q) ? rd.response : '0;
      tatr_q  <= (!done_q && fin_q) ? tat_q : '0;
      wait_q  <= (!done_q && fin_q) ? wt : '0;
      doner_q <= done_q;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.pid             = pid_q;
  assign rsp_o.slice_length    = slice_q;
  assign rsp_o.end_time        = end_q;
  assign rsp_o.finished        = finr_q;
  assign rsp_o.resp_delay      = resp_q;
  assign rsp_o.turnaround_time = tatr_q;
  assign rsp_o.wait_len        = wait_q;
  assign rsp_o.all_done        = doner_q;

  a_count_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= loaded_q) else $error("ready queue holds more than loaded");

  a_admit_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nta_q <= loaded_q) else $error("admit pointer past loaded entries");

  a_loaded_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CntW'(rrs_pkg::MaxProcs)) else $error("table overfilled");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && doner_q |-> pid_q == '0 && !finr_q && slice_q == '0)
    else $error("all_done response carries slice data");

  a_run_needs_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> count_q != '0) else $error("dispatch from empty queue");

endmodule
